### rtl/assert_macros.svh
// Assertion macros for the interpolator RTL.
// Included by files that check their own logic; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

### rtl/fpci_pkg.sv
// Package for the four-point curve interpolator: widths, constants, codes.
// Used by fpci_mac and four_point_curve_interpolator_core; no dependencies.
package fpci_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int TW            = FRACTION_BITS + 1;   // fraction port
    localparam int HQ            = 14;                  // Q2.14 register scale
    localparam int HW            = 16;                  // tension / bias width

    // Internal widths
    localparam int NW   = SAMPLE_BITS + 4;              // small polynomial coefs
    localparam int MPW  = HW + SAMPLE_BITS + 2;         // weighted slope sum
    localparam int SW   = HQ + 3;                       // 1 - tension
    localparam int MW   = MPW + SW;                     // Hermite tangent
    localparam int CW   = MW + 2;                       // wide coefficients
    localparam int KS   = 2 * HQ + 1;                   // Hermite sample scale
    localparam int NS   = 2 * HQ;                       // alignment of other modes
    localparam int AW   = CW + FRACTION_BITS + 1;       // first Horner sum
    localparam int MX_W = AW + FRACTION_BITS + 1;       // mac operand width
    localparam int MR_W = MX_W + FRACTION_BITS + 1;     // mac result width
    localparam int RSH  = 3 * FRACTION_BITS + 2 * HQ + 1; // final scale
    localparam int QW   = MR_W - RSH;                   // integer part width

    // Chunked multiply inside the mac stage
    localparam int CH_W  = 32;
    localparam int NCH   = (MX_W + CH_W - 1) / CH_W;
    localparam int TOP_W = MX_W - (NCH - 1) * CH_W;
    localparam int PP_W  = CH_W + TW + 2;

    // Accept edge to result strobe
    localparam int LAT = 10;

    // Register port
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Constants
    localparam logic [TW-1:0] F_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic signed [SW-1:0] S_ONE = {3'b001, {HQ{1'b0}}};
    localparam logic signed [CW-1:0] C0_HALF = {{(CW-NS-1){1'b0}}, 1'b1, {NS{1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [QW-1:0] Q_MAX = QW'(OUT_MAX);
    localparam logic signed [QW-1:0] Q_MIN = QW'(OUT_MIN);

    // Interpolation modes
    typedef enum logic [1:0] {
        MODE_LINEAR  = 2'd0,
        MODE_CUBIC   = 2'd1,
        MODE_CATMULL = 2'd2,
        MODE_HERMITE = 2'd3
    } t_mode;

    // Register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_TENSION = 2'd1,
        REG_BIAS    = 2'd2
    } t_reg_idx;

endpackage

### rtl/fpci_mac.sv
// Two-stage multiply-accumulate for one Horner step: y = x * t + add.
// Depends on fpci_pkg for widths; x is split into 32-bit chunks.
module fpci_mac import fpci_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_vld,
    input  logic signed [MX_W-1:0] i_x,
    input  logic        [TW-1:0]   i_t,
    input  logic signed [MR_W-1:0] i_add,
    output logic                   o_vld,
    output logic signed [MR_W-1:0] o_y
);

    logic signed [PP_W-1:0] n_pp [NCH];
    logic signed [PP_W-1:0] r_pp [NCH];
    logic signed [MR_W-1:0] r_add;
    logic signed [MR_W-1:0] n_y;
    logic signed [MR_W-1:0] r_y;
    logic                   r_vld_a;
    logic                   r_vld_b;

    function automatic logic signed [PP_W-1:0] pp_mul(
        input logic signed [PP_W-1:0] a,
        input logic signed [PP_W-1:0] b
    );
        return a * b;
    endfunction

    // Partial products: low chunks unsigned, top chunk carries the sign
    always_comb begin
        for (int k = 0; k < NCH - 1; k++) begin
            n_pp[k] = pp_mul(PP_W'(signed'({1'b0, i_x[k*CH_W +: CH_W]})),
                             PP_W'(signed'({1'b0, i_t})));
        end
        n_pp[NCH-1] = pp_mul(PP_W'(signed'(i_x[MX_W-1:(NCH-1)*CH_W])),
                             PP_W'(signed'({1'b0, i_t})));
    end

    // Align and sum the partial products with the addend
    always_comb begin
        n_y = r_add;
        for (int k = 0; k < NCH; k++) begin
            n_y = n_y + (MR_W'(r_pp[k]) <<< (k * CH_W));
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        r_pp  <= n_pp;
        r_add <= i_add;
        r_y   <= n_y;
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    assign o_vld = r_vld_b;
    assign o_y   = r_y;

endmodule

### rtl/four_point_curve_interpolator_core.sv
// Top level of the four-point curve interpolator: register port and pipeline.
// Depends on fpci_pkg, fpci_mac and assert_macros.svh.
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------
//  request   start / busy              i_sample_0..3, i_fraction
//  result    o_valid (one-cycle)       o_interpolated, o_saturated
//  config    psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One request per clock; busy is never raised.
// A result passes three setup stages, three two-stage Horner multiply-accumulates
// and one round/saturate stage between the accepting edge and its strobe.
// Synchronous active-low reset clears valid bits, tension and bias; mode resets to Catmull-Rom.
// No stall path: every stage advances every cycle.
`include "assert_macros.svh"
module four_point_curve_interpolator_core import fpci_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request
    input  logic                          start,
    output logic                          busy,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_0,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_1,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_2,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_3,
    input  logic        [TW-1:0]          i_fraction,
    // result
    output logic                          o_valid,
    output logic signed [SAMPLE_BITS-1:0] o_interpolated,
    output logic                          o_saturated,
    // config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [APB_AW-1:0]      paddr,
    input  logic        [APB_DW-1:0]      pwdata,
    output logic        [APB_DW-1:0]      prdata,
    output logic                          pready
);

    // Configuration registers
    t_mode                 r_mode;
    logic signed [HW-1:0]  r_tension;
    logic signed [HW-1:0]  r_bias;

    // Stage 1
    logic                  r1_vld;
    t_mode                 r1_mode;
    logic [TW-1:0]         r1_t;
    logic signed [NW-1:0]  r1_c3, r1_c2, r1_c1, r1_c0;
    logic signed [SAMPLE_BITS-1:0] r1_y1, r1_y2;
    logic signed [MPW-1:0] r1_m0p, r1_m1p;
    logic [TW-1:0]         n1_t;
    logic signed [NW-1:0]  n1_c3, n1_c2, n1_c1, n1_c0;
    logic signed [MPW-1:0] n1_m0p, n1_m1p;

    // Stage 2
    logic                  r2_vld;
    t_mode                 r2_mode;
    logic [TW-1:0]         r2_t;
    logic signed [NW-1:0]  r2_c3, r2_c2, r2_c1, r2_c0;
    logic signed [SAMPLE_BITS-1:0] r2_y1, r2_y2;
    logic signed [MW-1:0]  r2_m0, r2_m1;
    logic signed [SW-1:0]  s_scale;

    // Stage 3
    logic                  r3_vld;
    logic [TW-1:0]         r3_t;
    logic signed [CW-1:0]  r3_c3, r3_c2, r3_c1, r3_c0;
    logic signed [CW-1:0]  n3_c3, n3_c2, n3_c1, n3_c0;

    // Delay lines beside the mac stages
    logic [TW-1:0]         r_t_d  [4];
    logic signed [CW-1:0]  r_c1_d [2];
    logic signed [CW-1:0]  r_c0_d [4];

    // Horner chain
    logic                  a_vld, b_vld, c_vld;
    logic signed [MR_W-1:0] a_y, b_y, c_y;

    // Output stage
    logic signed [QW-1:0]  q_int;
    logic                  r_ovld;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                  r_sat;
    logic signed [SAMPLE_BITS-1:0] n_out;
    logic                  n_sat;

    logic cfg_wr;

    // ---------------- register port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_CATMULL;
            r_tension <= '0;
            r_bias    <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MODE:    r_mode    <= t_mode'(pwdata[1:0]);
                REG_TENSION: r_tension <= pwdata[HW-1:0];
                REG_BIAS:    r_bias    <= pwdata[HW-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (paddr[3:2])
            REG_MODE:    prdata = {{(APB_DW-2){1'b0}}, r_mode};
            REG_TENSION: prdata = {{(APB_DW-HW){1'b0}}, r_tension};
            REG_BIAS:    prdata = {{(APB_DW-HW){1'b0}}, r_bias};
            default:     prdata = '0;
        endcase
    end

    // Fully pipelined: a new request every cycle
    assign busy = 1'b0;

    // ---------------- stage 1: clamp, small coefficients, slope sums ----------------
    always_comb begin
        logic signed [NW-1:0]  y0, y1, y2, y3, a0, a1;
        logic signed [MPW-1:0] w0, w1, w2, w3, e0, e1;
        y0 = NW'(i_sample_0);
        y1 = NW'(i_sample_1);
        y2 = NW'(i_sample_2);
        y3 = NW'(i_sample_3);
        n1_t = (i_fraction > F_ONE) ? F_ONE : i_fraction;

        // polynomial in t, scaled so all non-Hermite modes share one shift
        a0 = y3 - y2 - y0 + y1;
        a1 = y0 - y1 - a0;
        case (r_mode)
            MODE_LINEAR: begin
                n1_c3 = '0;
                n1_c2 = '0;
                n1_c1 = (y2 - y1) <<< 1;
                n1_c0 = y1 <<< 1;
            end
            MODE_CUBIC: begin
                n1_c3 = a0 <<< 1;
                n1_c2 = a1 <<< 1;
                n1_c1 = (y2 - y0) <<< 1;
                n1_c0 = y1 <<< 1;
            end
            MODE_CATMULL: begin
                n1_c3 = -y0 + ((y1 <<< 1) + y1) - ((y2 <<< 1) + y2) + y3;
                n1_c2 = (y0 <<< 1) - ((y1 <<< 2) + y1) + (y2 <<< 2) - y3;
                n1_c1 = y2 - y0;
                n1_c0 = y1 <<< 1;
            end
            default: begin
                n1_c3 = '0;
                n1_c2 = '0;
                n1_c1 = '0;
                n1_c0 = '0;
            end
        endcase

        // Hermite slope sums before the tension factor
        w0 = MPW'(i_sample_0);
        w1 = MPW'(i_sample_1);
        w2 = MPW'(i_sample_2);
        w3 = MPW'(i_sample_3);
        e0 = (w1 <<< 1) - w0 - w2;
        e1 = (w2 <<< 1) - w1 - w3;
        n1_m0p = ((w2 - w0) <<< HQ) + MPW'(r_bias) * e0;
        n1_m1p = ((w3 - w1) <<< HQ) + MPW'(r_bias) * e1;
    end

    always_ff @(posedge i_clk) begin
        r1_mode <= r_mode;
        r1_t    <= n1_t;
        r1_c3   <= n1_c3;
        r1_c2   <= n1_c2;
        r1_c1   <= n1_c1;
        r1_c0   <= n1_c0;
        r1_y1   <= i_sample_1;
        r1_y2   <= i_sample_2;
        r1_m0p  <= n1_m0p;
        r1_m1p  <= n1_m1p;
    end

    // ---------------- stage 2: tangents scaled by (1 - tension) ----------------
    assign s_scale = S_ONE - SW'(r_tension);

    always_ff @(posedge i_clk) begin
        r2_mode <= r1_mode;
        r2_t    <= r1_t;
        r2_c3   <= r1_c3;
        r2_c2   <= r1_c2;
        r2_c1   <= r1_c1;
        r2_c0   <= r1_c0;
        r2_y1   <= r1_y1;
        r2_y2   <= r1_y2;
        r2_m0   <= MW'(r1_m0p) * MW'(s_scale);
        r2_m1   <= MW'(r1_m1p) * MW'(s_scale);
    end

    // ---------------- stage 3: wide coefficients, rounding half folded into c0 ----------------
    always_comb begin
        logic signed [CW-1:0] dy, m0, m1;
        dy = CW'(r2_y1) - CW'(r2_y2);
        m0 = CW'(r2_m0);
        m1 = CW'(r2_m1);
        if (r2_mode == MODE_HERMITE) begin
            n3_c3 = (dy <<< (KS + 1)) + m0 + m1;
            n3_c2 = -((dy <<< (KS + 1)) + (dy <<< KS)) - (m0 <<< 1) - m1;
            n3_c1 = m0;
            n3_c0 = (CW'(r2_y1) <<< KS) + C0_HALF;
        end else begin
            n3_c3 = CW'(r2_c3) <<< NS;
            n3_c2 = CW'(r2_c2) <<< NS;
            n3_c1 = CW'(r2_c1) <<< NS;
            n3_c0 = (CW'(r2_c0) <<< NS) + C0_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_t  <= r2_t;
        r3_c3 <= n3_c3;
        r3_c2 <= n3_c2;
        r3_c1 <= n3_c1;
        r3_c0 <= n3_c0;
    end

    // Operands that wait beside the mac stages
    always_ff @(posedge i_clk) begin
        r_t_d[0]  <= r3_t;
        r_t_d[1]  <= r_t_d[0];
        r_t_d[2]  <= r_t_d[1];
        r_t_d[3]  <= r_t_d[2];
        r_c1_d[0] <= r3_c1;
        r_c1_d[1] <= r_c1_d[0];
        r_c0_d[0] <= r3_c0;
        r_c0_d[1] <= r_c0_d[0];
        r_c0_d[2] <= r_c0_d[1];
        r_c0_d[3] <= r_c0_d[2];
    end

    // Valid bits of the setup stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    // ---------------- Horner: ((c3 t + c2 F) t + c1 F^2) t + c0 F^3 ----------------
    fpci_mac u_mac_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_x     (MX_W'(r3_c3)),
        .i_t     (r3_t),
        .i_add   (MR_W'(r3_c2) <<< FRACTION_BITS),
        .o_vld   (a_vld),
        .o_y     (a_y)
    );

    fpci_mac u_mac_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (a_vld),
        .i_x     (a_y[MX_W-1:0]),
        .i_t     (r_t_d[1]),
        .i_add   (MR_W'(r_c1_d[1]) <<< (2 * FRACTION_BITS)),
        .o_vld   (b_vld),
        .o_y     (b_y)
    );

    fpci_mac u_mac_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (b_vld),
        .i_x     (b_y[MX_W-1:0]),
        .i_t     (r_t_d[3]),
        .i_add   (MR_W'(r_c0_d[3]) <<< (3 * FRACTION_BITS)),
        .o_vld   (c_vld),
        .o_y     (c_y)
    );

    // ---------------- output: floor shift and saturation ----------------
    assign q_int = c_y[MR_W-1:RSH];

    always_comb begin
        if (q_int > Q_MAX) begin
            n_out = OUT_MAX;
            n_sat = 1'b1;
        end else if (q_int < Q_MIN) begin
            n_out = OUT_MIN;
            n_sat = 1'b1;
        end else begin
            n_out = q_int[SAMPLE_BITS-1:0];
            n_sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_sat <= n_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= c_vld;
        end
    end

    assign o_valid        = r_ovld;
    assign o_interpolated = r_out;
    assign o_saturated    = r_sat;

    // ---------------- checks ----------------
    `ASSERT_PROP(a_latency, i_clk, i_rst_n, start && !busy |-> ##LAT o_valid)
    `ASSERT_PROP(a_left_end, i_clk, i_rst_n, start && !busy && i_fraction == '0 |-> ##LAT (o_interpolated == $past(i_sample_1, LAT) && !o_saturated))
    `ASSERT_PROP(a_right_end, i_clk, i_rst_n, start && !busy && i_fraction[FRACTION_BITS] |-> ##LAT (o_interpolated == $past(i_sample_2, LAT) && !o_saturated))
    `ASSERT_NEVER(a_sat_rail, i_clk, i_rst_n, o_valid && o_saturated && o_interpolated != OUT_MAX && o_interpolated != OUT_MIN)

endmodule

### tb/four_point_curve_interpolator_core_tb.sv
// Self-checking testbench for four_point_curve_interpolator_core.
// Directed table, then random requests under all modes, checked against an exact
// wide-integer predictor; depends on fpci_pkg and the core RTL.
module four_point_curve_interpolator_core_tb;
    import fpci_pkg::*;

    localparam int WIDE        = 192;
    localparam int N_PHASES    = 12;
    localparam int PHASE_ITEMS = 138;
    localparam int QUIET_PHASE = 10;   // phases from here on run without gaps

    typedef logic signed [WIDE-1:0] wide_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic                          sat;
    } point_t;

    typedef struct {
        t_mode                         mode;
        logic signed [HW-1:0]          tension;
        logic signed [HW-1:0]          bias;
        logic signed [SAMPLE_BITS-1:0] y0;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
        logic signed [SAMPLE_BITS-1:0] y3;
        logic        [TW-1:0]          frac;
        bit                            typed;
        point_t                        want;
    } dir_row_t;

    localparam int N_DIR = 23;

    // DUT signals
    logic                          i_clk;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic signed [SAMPLE_BITS-1:0] i_sample_0 = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_1 = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_2 = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_3 = '0;
    logic        [TW-1:0]          i_fraction = '0;
    logic                          o_valid;
    logic signed [SAMPLE_BITS-1:0] o_interpolated;
    logic                          o_saturated;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic        [APB_AW-1:0]      paddr = '0;
    logic        [APB_DW-1:0]      pwdata = '0;
    logic        [APB_DW-1:0]      prdata;
    logic                          pready;

    // Register shadow, expected points, error tally
    t_mode                cfg_mode = MODE_CATMULL;
    logic signed [HW-1:0] cfg_tension = '0;
    logic signed [HW-1:0] cfg_bias = '0;
    point_t               pending_points[$];
    point_t               head_point;
    int                   error_count = 0;
    int                   reg_corners[5] = '{-32768, -16384, 0, 16384, 32767};
    dir_row_t             dir_rows[N_DIR];

    four_point_curve_interpolator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_sample_0     (i_sample_0),
        .i_sample_1     (i_sample_1),
        .i_sample_2     (i_sample_2),
        .i_sample_3     (i_sample_3),
        .i_fraction     (i_fraction),
        .o_valid        (o_valid),
        .o_interpolated (o_interpolated),
        .o_saturated    (o_saturated),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // Exact interpolation: numerator over 2^shift, round half up, clamp
    function automatic point_t interpolate_point(
        input t_mode                         mode,
        input logic signed [HW-1:0]          ten,
        input logic signed [HW-1:0]          bia,
        input logic signed [SAMPLE_BITS-1:0] s0,
        input logic signed [SAMPLE_BITS-1:0] s1,
        input logic signed [SAMPLE_BITS-1:0] s2,
        input logic signed [SAMPLE_BITS-1:0] s3,
        input logic        [TW-1:0]          frac
    );
        wide_t  y0, y1, y2, y3, mu, one_f, mu2, mu3, mu2f, muf2, f3;
        wide_t  c0, c1, hone, tw, bw, p_w, q_w, m0, m1;
        wide_t  h00, h10, h01, h11, acc, half;
        int     shift;
        point_t res;
        y0 = s0;
        y1 = s1;
        y2 = s2;
        y3 = s3;
        // fraction above one is pinned to exactly one
        mu = (frac > F_ONE) ? F_ONE : frac;
        one_f = F_ONE;
        mu2 = mu * mu;
        mu3 = mu2 * mu;
        mu2f = mu2 * one_f;
        muf2 = mu * one_f * one_f;
        f3 = one_f * one_f * one_f;
        case (mode)
            MODE_LINEAR: begin
                acc = y1 * (one_f - mu) + y2 * mu;
                shift = FRACTION_BITS;
            end
            MODE_CUBIC: begin
                c0 = y3 - y2 - y0 + y1;
                c1 = y0 - y1 - c0;
                acc = c0 * mu3 + c1 * mu2f + (y2 - y0) * muf2 + y1 * f3;
                shift = 3 * FRACTION_BITS;
            end
            MODE_CATMULL: begin
                acc = (3 * y1 - y0 - 3 * y2 + y3) * mu3
                    + (2 * y0 - 5 * y1 + 4 * y2 - y3) * mu2f
                    + (y2 - y0) * muf2 + 2 * y1 * f3;
                shift = 3 * FRACTION_BITS + 1;
            end
            default: begin
                // tangents carry (1+b)(1-t) and (1-b)(1-t) in Q4.28, halved below
                hone = wide_t'(1) <<< HQ;
                tw = ten;
                bw = bia;
                p_w = (hone + bw) * (hone - tw);
                q_w = (hone - bw) * (hone - tw);
                m0 = (y1 - y0) * p_w + (y2 - y1) * q_w;
                m1 = (y2 - y1) * p_w + (y3 - y2) * q_w;
                h00 = f3 + 2 * mu3 - 3 * mu2f;
                h10 = mu3 + muf2 - 2 * mu2f;
                h01 = mu3 - mu2f;
                h11 = 3 * mu2f - 2 * mu3;
                acc = ((h00 * y1 + h11 * y2) <<< (2 * HQ + 1)) + h10 * m0 + h01 * m1;
                shift = 3 * FRACTION_BITS + 2 * HQ + 1;
            end
        endcase
        half = wide_t'(1) <<< (shift - 1);
        acc = (acc + half) >>> shift;
        if (acc > wide_t'(OUT_MAX)) begin
            res.value = OUT_MAX;
            res.sat = 1'b1;
        end else if (acc < wide_t'(OUT_MIN)) begin
            res.value = OUT_MIN;
            res.sat = 1'b1;
        end else begin
            res.value = acc[SAMPLE_BITS-1:0];
            res.sat = 1'b0;
        end
        return res;
    endfunction

    // One request; holds start high until the accepting edge
    task automatic send_request(
        input logic signed [SAMPLE_BITS-1:0] s0,
        input logic signed [SAMPLE_BITS-1:0] s1,
        input logic signed [SAMPLE_BITS-1:0] s2,
        input logic signed [SAMPLE_BITS-1:0] s3,
        input logic        [TW-1:0]          frac,
        input bit                            typed,
        input point_t                        want
    );
        start <= 1'b1;
        i_sample_0 <= s0;
        i_sample_1 <= s1;
        i_sample_2 <= s2;
        i_sample_3 <= s3;
        i_fraction <= frac;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (typed) pending_points.push_back(want);
        else pending_points.push_back(interpolate_point(cfg_mode, cfg_tension, cfg_bias,
                                                        s0, s1, s2, s3, frac));
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        start <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup and access phase; ends with the bus released
    task automatic apb_access(input bit wr, input t_reg_idx idx,
                              input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, update the shadow, read it back
    task automatic set_register(input t_reg_idx idx, input logic [HW-1:0] val);
        logic [APB_DW-1:0] data;
        logic [APB_DW-1:0] rd;
        data = $urandom;
        if (idx == REG_MODE) data[1:0] = val[1:0];
        else data[HW-1:0] = val;
        apb_access(1'b1, idx, data, rd);
        case (idx)
            REG_MODE:    cfg_mode = t_mode'(val[1:0]);
            REG_TENSION: cfg_tension = val;
            default:     cfg_bias = val;
        endcase
        apb_access(1'b0, idx, '0, rd);
        if (idx == REG_MODE ? (rd[1:0] !== val[1:0]) : (rd[HW-1:0] !== val))
            report_mismatch($sformatf("register %0d reads 0x%0h, wrote 0x%0h",
                                      idx, rd, val));
    endtask

    task automatic apply_config(input t_mode mode, input logic signed [HW-1:0] ten,
                                input logic signed [HW-1:0] bia);
        drain_results();
        set_register(REG_MODE, HW'(mode));
        set_register(REG_TENSION, ten);
        set_register(REG_BIAS, bia);
    endtask

    // Random request: smooth runs, full-range noise, corner values
    task automatic pick_request(output logic signed [SAMPLE_BITS-1:0] s0,
                                output logic signed [SAMPLE_BITS-1:0] s1,
                                output logic signed [SAMPLE_BITS-1:0] s2,
                                output logic signed [SAMPLE_BITS-1:0] s3,
                                output logic        [TW-1:0]          frac);
        int vals[4];
        int corner_vals[6] = '{-32768, -32767, -1, 0, 1, 32767};
        int base;
        int step;
        int kind;
        kind = $urandom_range(0, 9);
        base = $urandom_range(0, 40000);
        base = base - 20000;
        step = $urandom_range(0, 4000);
        step = step - 2000;
        for (int k = 0; k < 4; k++) begin
            if (kind <= 3) begin
                vals[k] = base + k * step + int'($urandom_range(0, 510)) - 255;
            end else if (kind <= 6) begin
                vals[k] = int'(16'($urandom));
            end else if (kind <= 8 || $urandom_range(0, 1) == 0) begin
                vals[k] = corner_vals[$urandom_range(0, 5)];
            end else begin
                vals[k] = int'(16'($urandom));
            end
        end
        s0 = vals[0][SAMPLE_BITS-1:0];
        s1 = vals[1][SAMPLE_BITS-1:0];
        s2 = vals[2][SAMPLE_BITS-1:0];
        s3 = vals[3][SAMPLE_BITS-1:0];
        case ($urandom_range(0, 9))
            7: begin
                case ($urandom_range(0, 3))
                    0:       frac = '0;
                    1:       frac = TW'(1);
                    2:       frac = F_ONE - 1'b1;
                    default: frac = F_ONE;
                endcase
            end
            8:       frac = TW'($urandom_range(32'h10001, 32'h1FFFF));
            9:       frac = TW'($urandom_range(0, 32'h1FFFF));
            default: frac = TW'($urandom_range(0, 32'h10000));
        endcase
    endtask

    // Result checker: the block cannot be stalled, so every strobe counts
    always @(posedge i_clk) begin
        if (o_valid === 1'b1) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("result %0d/%0b with none expected",
                                          o_interpolated, o_saturated));
            end else begin
                head_point = pending_points.pop_front();
                if (o_interpolated !== head_point.value || o_saturated !== head_point.sat)
                    report_mismatch($sformatf("got %0d sat %0b, expected %0d sat %0b",
                                              o_interpolated, o_saturated,
                                              head_point.value, head_point.sat));
            end
        end
    end

    // Stimulus
    initial begin
        logic signed [SAMPLE_BITS-1:0] s0, s1, s2, s3;
        logic        [TW-1:0]          frac;
        t_mode                         ph_mode;
        logic signed [HW-1:0]          ph_ten;
        logic signed [HW-1:0]          ph_bias;
        bit                            idle_gate;

        // mode, tension, bias, samples, fraction, typed check, expected point
        dir_rows = '{
            // reset settings: Catmull-Rom ends, fraction above one, overshoot clamp
            '{MODE_CATMULL, 0, 0, 0, 100, 200, 300, 17'h00000, 1, '{100, 1'b0}},
            '{MODE_CATMULL, 0, 0, 0, 100, 200, 300, 17'h10000, 1, '{200, 1'b0}},
            '{MODE_CATMULL, 0, 0, 0, 100, 200, 300, 17'h1FFFF, 1, '{200, 1'b0}},
            '{MODE_CATMULL, 0, 0, -32768, 32767, 32767, -32768, 17'h08000, 1,
              '{32767, 1'b1}},
            '{MODE_CATMULL, 0, 0, 32767, -32768, -32768, 32767, 17'h08000, 1,
              '{-32768, 1'b1}},
            '{MODE_CATMULL, 0, 0, 100, -200, 300, -400, 17'd12345, 0, '{0, 1'b0}},
            // linear: extremes, exact half rounds up to zero
            '{MODE_LINEAR, 0, 0, 0, -32768, 32767, 0, 17'h00000, 1, '{-32768, 1'b0}},
            '{MODE_LINEAR, 0, 0, 0, -32768, 32767, 0, 17'h10000, 1, '{32767, 1'b0}},
            '{MODE_LINEAR, 0, 0, 0, -32768, 32767, 0, 17'h08000, 1, '{0, 1'b0}},
            '{MODE_LINEAR, 0, 0, 0, -32768, 32767, 0, 17'h10001, 1, '{32767, 1'b0}},
            '{MODE_LINEAR, 0, 0, 5, 7, -9, 11, 17'h00001, 0, '{0, 1'b0}},
            // plain cubic
            '{MODE_CUBIC, 0, 0, 1000, -1000, 2000, -3000, 17'h00000, 1, '{-1000, 1'b0}},
            '{MODE_CUBIC, 0, 0, 1000, -1000, 2000, -3000, 17'h10000, 1, '{2000, 1'b0}},
            '{MODE_CUBIC, 0, 0, 32767, -32768, 32767, -32768, 17'h08000, 0, '{0, 1'b0}},
            '{MODE_CUBIC, 0, 0, -32768, 32767, -32768, 32767, 17'd21845, 0, '{0, 1'b0}},
            // Hermite: ends, full tension gives flat tangents, registers out of range
            '{MODE_HERMITE, 0, 0, 10, 20, 40, 80, 17'h00000, 1, '{20, 1'b0}},
            '{MODE_HERMITE, 0, 0, 10, 20, 40, 80, 17'h10000, 1, '{40, 1'b0}},
            '{MODE_HERMITE, 16384, 0, 0, 0, 1000, 0, 17'h08000, 1, '{500, 1'b0}},
            '{MODE_HERMITE, -16384, 16384, -32768, 32767, -32768, 32767, 17'h08000, 0,
              '{0, 1'b0}},
            '{MODE_HERMITE, -32768, 32767, 32767, -32768, 32767, -32768, 17'h04000, 0,
              '{0, 1'b0}},
            '{MODE_HERMITE, 32767, -32768, -32768, -32768, 32767, 32767, 17'h0C000, 0,
              '{0, 1'b0}},
            '{MODE_HERMITE, 16384, -16384, 1, -1, 0, -1, 17'h1FFFF, 1, '{0, 1'b0}},
            '{MODE_HERMITE, 0, 0, -32768, 32767, -32768, 32767, 17'h0FFFF, 0, '{0, 1'b0}}
        };

        // reset
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; registers change only between drained groups
        foreach (dir_rows[r]) begin
            if (dir_rows[r].mode != cfg_mode || dir_rows[r].tension != cfg_tension ||
                dir_rows[r].bias != cfg_bias)
                apply_config(dir_rows[r].mode, dir_rows[r].tension, dir_rows[r].bias);
            send_request(dir_rows[r].y0, dir_rows[r].y1, dir_rows[r].y2, dir_rows[r].y3,
                         dir_rows[r].frac, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < N_PHASES; phase++) begin
            ph_mode = t_mode'(phase % 4);
            ph_ten = (phase % 3 == 2) ? HW'($urandom) : HW'(reg_corners[$urandom_range(0, 4)]);
            ph_bias = (phase % 3 == 1) ? HW'($urandom) : HW'(reg_corners[$urandom_range(0, 4)]);
            apply_config(ph_mode, ph_ten, ph_bias);
            idle_gate = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) idle_gate = ($urandom_range(0, 2) != 0);
                // one mid-phase hold-off until the pipeline is empty
                if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
                else if (phase < QUIET_PHASE && idle_gate && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 6));
                pick_request(s0, s1, s2, s3, frac);
                send_request(s0, s1, s2, s3, frac, 1'b0, '0);
            end
        end

        drain_results();
        repeat (LAT + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
